// ===== src/fpdsf_pkg.sv =====
// Package for the FEC parity DSSS symbol framer.
// Holds the frame layout constants, the parity function and the structs
// passed between the front end, the frame queue and the symbol serializer.
package fpdsf_pkg;

    // Frame layout.
    localparam int unsigned FRAME_LEN = 30;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned IDX_W     = 5;
    localparam int unsigned AMBLE_W   = 7;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = '0;

    localparam logic [AMBLE_W-1:0] PREAMBLE  = 7'b1110010;
    localparam logic [AMBLE_W-1:0] POSTAMBLE = 7'b1011000;

    // Parity masks of the (16,8,5) code, entry k feeds parity bit k.
    localparam logic [DATA_W-1:0] PARITY_MASK [DATA_W] = '{
        8'h39, 8'hDD, 8'hF1, 8'hE2, 8'h8F, 8'h1E, 8'h77, 8'hA5
    };

    typedef logic [FRAME_LEN-1:0] t_frame;

    // One frame word pushed from the front end into the queue.
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_frame_push;

    // Head of the queue as seen by the serializer.
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_frame_head;

    // Even parity of the data bits that each mask selects.
    function automatic logic [DATA_W-1:0] block_parity(input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] p;
        p = '0;
        for (int k = 0; k < int'(DATA_W); k++) begin
            p[k] = ^(d & PARITY_MASK[k]);
        end
        return p;
    endfunction

    // Whole frame word, symbol 0 in the top bit.
    function automatic t_frame build_frame(input logic [DATA_W-1:0] d);
        return {PREAMBLE, block_parity(d), d, POSTAMBLE};
    endfunction

endpackage

// ===== src/fpdsf_front.sv =====
// Front end of the framer: accepts data bytes and turns each into a frame word.
// Depends on fpdsf_pkg for the parity function and the push struct.
module fpdsf_front (
    input  logic                       i_tvalid,
    input  logic [fpdsf_pkg::DATA_W-1:0] i_tdata,
    output logic                       o_tready,
    output fpdsf_pkg::t_frame_push     o_push,
    input  logic                       i_push_ready
);

    // A byte is taken whenever the queue has room for its frame.
    assign o_tready     = i_push_ready;
    assign o_push.valid = i_tvalid;

    // Parity and frame assembly in one step.
    assign o_push.frame = fpdsf_pkg::build_frame(i_tdata);

endmodule

// ===== src/fpdsf_queue.sv =====
// Short queue of frame words between the front end and the serializer.
// Depends on fpdsf_pkg for the frame word and the struct types.
module fpdsf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fpdsf_pkg::t_frame_push i_push,
    output logic                   o_push_ready,
    output fpdsf_pkg::t_frame_head o_head,
    input  logic                   i_pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fpdsf_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.frame = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Frame storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

endmodule

// ===== src/fpdsf_serializer.sv =====
// Back end of the framer: shifts each frame word out one symbol per transfer.
// Depends on fpdsf_pkg for the frame layout and the queue head struct.
module fpdsf_serializer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpdsf_pkg::t_frame_head       i_head,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic                         o_code_select,
    output logic [fpdsf_pkg::IDX_W-1:0]  o_symbol_index,
    output logic                         o_tlast
);

    logic                        r_busy, n_busy;
    fpdsf_pkg::t_frame           r_frame, n_frame;
    logic [fpdsf_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                        w_xfer, w_done, w_load;

    assign w_xfer = r_busy && i_tready;
    assign w_done = w_xfer && (r_idx == fpdsf_pkg::LAST_IDX);
    // The next frame is taken as the current one finishes, with no gap.
    assign w_load = i_head.valid && (!r_busy || w_done);
    assign o_pop  = w_load;

    assign o_tvalid       = r_busy;
    assign o_code_select  = r_frame[fpdsf_pkg::FRAME_LEN-1];
    assign o_symbol_index = r_idx;
    assign o_tlast        = (r_idx == fpdsf_pkg::LAST_IDX);

    // Load, shift or go idle.
    always_comb begin
        n_busy  = r_busy;
        n_frame = r_frame;
        n_idx   = r_idx;
        if (w_load) begin
            n_busy  = 1'b1;
            n_frame = i_head.frame;
            n_idx   = fpdsf_pkg::FIRST_IDX;
        end else if (w_done) begin
            n_busy = 1'b0;
        end else if (w_xfer) begin
            n_frame = {r_frame[fpdsf_pkg::FRAME_LEN-2:0], 1'b0};
            n_idx   = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= fpdsf_pkg::FIRST_IDX;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // The frame shift register is payload only.
    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

endmodule

// ===== src/fec_parity_dsss_symbol_framer.sv =====
// A byte's frame word is written into the queue, then loaded into the serializer, before
// its first symbol is offered. The serializer gives one symbol per cycle while m_axis_tready
// is high, thirty symbols per byte, and moves straight on to the next frame when the queue holds one.
// The queue takes QUEUE_DEPTH bytes ahead of the serializer, so input keeps flowing until it is full.
// Reset (synchronous, active low) empties the queue and idles the serializer at once.
// Top level of the FEC parity DSSS symbol framer; uses fpdsf_pkg and all fpdsf modules.
module fec_parity_dsss_symbol_framer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] code_select, [5:1] symbol_index, [7:6] zero
    output logic       m_axis_tlast    // last_symbol
);

    fpdsf_pkg::t_frame_push      w_push;
    fpdsf_pkg::t_frame_head      w_head;
    logic                        w_push_ready;
    logic                        w_pop;
    logic                        w_code_select;
    logic [fpdsf_pkg::IDX_W-1:0] w_symbol_index;

    // Byte intake and frame assembly.
    fpdsf_front u_front (
        .i_tvalid     (s_axis_tvalid),
        .i_tdata      (s_axis_tdata),
        .o_tready     (s_axis_tready),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    // Frame words waiting for the serializer.
    fpdsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // Symbol output.
    fpdsf_serializer u_serializer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_tvalid       (m_axis_tvalid),
        .i_tready       (m_axis_tready),
        .o_code_select  (w_code_select),
        .o_symbol_index (w_symbol_index),
        .o_tlast        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_symbol_index, w_code_select};

`ifndef SYNTHESIS
    // A finished frame with another queued is followed at once by symbol 0.
    a_frame_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast && w_head.valid
        |=> m_axis_tvalid && (w_symbol_index == fpdsf_pkg::FIRST_IDX))
        else $error("next queued frame did not start after last symbol");

    // Every symbol transfer other than the last advances the index by one.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && (w_symbol_index == $past(w_symbol_index) + 1'b1))
        else $error("symbol index did not advance");

    // The serializer only pops a frame the queue actually holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty frame queue");

    // Input is held off only while the queue is full and the serializer is busy.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && w_head.valid)
        else $error("input stalled with room downstream");
`endif

endmodule

// ===== bench/fec_parity_dsss_symbol_framer_tb.sv =====
// Self-checking testbench for the FEC parity DSSS symbol framer.
// Predicts each byte's thirty-symbol frame and checks every output transfer against it.
// Depends only on the RTL top level fec_parity_dsss_symbol_framer.
module fec_parity_dsss_symbol_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SYMBOLS_PER_FRAME = 30;
    localparam int RANDOM_BYTES      = 404;
    localparam int IDLE_PERCENT      = 28;
    localparam int QUIET_FIRST       = 150;
    localparam int QUIET_LAST        = 260;
    localparam int DRAIN_POINT       = 300;
    localparam int SETTLE_CYCLES     = 40;
    localparam int STALL_LIMIT       = 2000;

    localparam logic [6:0] SYNC_HEAD = 7'b1110010;
    localparam logic [6:0] SYNC_TAIL = 7'b1011000;

    // Masks of the (16,8,5) code; entry k gives the data bits summed into check bit k.
    localparam logic [7:0] CHECK_MASKS [8] = '{
        8'h39, 8'hDD, 8'hF1, 8'hE2, 8'h8F, 8'h1E, 8'h77, 8'hA5
    };

    // One output symbol as the block should present it.
    typedef struct packed {
        logic       code_select;
        logic [4:0] symbol_index;
        logic       last_symbol;
    } symbol_t;

    // One directed byte, with its check bits typed in where they are obvious.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       check_known;
        logic [7:0] check_bits;
    } byte_row_t;

    localparam int DIRECTED_ROWS = 18;
    localparam byte_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 8'h00},
        '{8'hFF, 1'b1, 8'h14},
        '{8'h01, 1'b0, 8'h00},
        '{8'h02, 1'b0, 8'h00},
        '{8'h04, 1'b0, 8'h00},
        '{8'h08, 1'b0, 8'h00},
        '{8'h10, 1'b0, 8'h00},
        '{8'h20, 1'b0, 8'h00},
        '{8'h40, 1'b0, 8'h00},
        '{8'h80, 1'b0, 8'h00},
        '{8'hFE, 1'b0, 8'h00},
        '{8'h7F, 1'b0, 8'h00},
        '{8'h55, 1'b0, 8'h00},
        '{8'hAA, 1'b0, 8'h00},
        '{8'h0F, 1'b0, 8'h00},
        '{8'hF0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 8'h00},
        '{8'hFF, 1'b1, 8'h14}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [0] code_select, [5:1] symbol_index, [7:6] zero
    logic       m_axis_tlast;            // last_symbol

    symbol_t symbols_due [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      no_idling      = 1'b0;

    fec_parity_dsss_symbol_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Even parity of the data under each mask gives the eight check bits.
    function automatic logic [7:0] code_parity(input logic [7:0] data_byte);
        logic [7:0] check;
        check = '0;
        for (int k = 0; k < 8; k++) begin
            check[k] = ^(data_byte & CHECK_MASKS[k]);
        end
        return check;
    endfunction

    // Lay out the frame, first symbol in the top bit, and queue its symbols in order.
    task automatic queue_frame_symbols(input logic [7:0] data_byte, input logic [7:0] check);
        logic [29:0] frame_word;
        symbol_t     sym;
        frame_word = {SYNC_HEAD, check, data_byte, SYNC_TAIL};
        for (int i = 0; i < SYMBOLS_PER_FRAME; i++) begin
            sym.code_select  = frame_word[29 - i];
            sym.symbol_index = 5'(i);
            sym.last_symbol  = (i == SYMBOLS_PER_FRAME - 1);
            symbols_due.push_back(sym);
        end
    endtask

    // Offer one byte after an optional random gap and wait for its transfer.
    // The valid stays high on return so back-to-back bytes need no second assignment.
    task automatic send_byte(input logic [7:0] data_byte, input logic check_known,
                             input logic [7:0] check_typed);
        if (!no_idling) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_byte;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_frame_symbols(data_byte, check_known ? check_typed : code_parity(data_byte));
    endtask

    // Hold the input off until every queued symbol has come out.
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (symbols_due.size() != 0) @(posedge i_clk);
    endtask

    // Output back-pressure, random except in the quiet stretch.
    always @(posedge i_clk) begin
        m_axis_tready <= no_idling ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Compare each output transfer with the oldest queued symbol.
    always @(posedge i_clk) begin
        symbol_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (symbols_due.size() == 0) begin
                $error("unexpected symbol transfer: tdata=%h tlast=%b",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = symbols_due.pop_front();
                if (m_axis_tdata[0] !== want.code_select) begin
                    $error("code_select: expected %b, got %b",
                           want.code_select, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[5:1] !== want.symbol_index) begin
                    $error("symbol_index: expected %0d, got %0d",
                           want.symbol_index, m_axis_tdata[5:1]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last_symbol) begin
                    $error("last_symbol: expected %b, got %b",
                           want.last_symbol, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:6] !== 2'b00) begin
                    $error("tdata padding: expected 0, got %b", m_axis_tdata[7:6]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Reset, directed bytes, then random bytes, then wait out the last frame.
    initial begin
        logic [7:0] rand_byte;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_byte(DIRECTED[r].data_byte, DIRECTED[r].check_known, DIRECTED[r].check_bits);
        end
        drain_frames();

        for (int n = 0; n < RANDOM_BYTES; n++) begin
            no_idling = (n >= QUIET_FIRST) && (n < QUIET_LAST);
            if (n == DRAIN_POINT) begin
                drain_frames();
            end
            // Mostly uniform bytes, with some weight on the all-zero, all-one, one-hot and one-cold cases.
            case ($urandom_range(9))
                0:       rand_byte = 8'h01 << $urandom_range(7);
                1:       rand_byte = ~(8'h01 << $urandom_range(7));
                2:       rand_byte = $urandom_range(1) ? 8'hFF : 8'h00;
                default: rand_byte = 8'($urandom_range(255));
            endcase
            send_byte(rand_byte, 1'b0, 8'h00);
        end
        no_idling = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (symbols_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (symbols_due.size() != 0) begin
            $error("%0d expected symbols never arrived", symbols_due.size());
            mismatch_count++;
        end

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
